[rtl/assert_macros.svh]
// Assertion macros used by the checker module of this block.
// Needs nothing else; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define RPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define RPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rpcfen_pkg.sv]
// Package for the rectangle point counter: field widths, opcodes, defaults.
// No dependencies; imported by the interfaces, the top level and the checker.
package rpcfen_pkg;

	localparam int OpW      = 2;
	localparam int CoordW   = 8;
	localparam int CountW   = 17;
	localparam int GridSizeDef = 256;

	// largest possible count: every cell of a 256 x 256 coordinate range
	localparam logic [CountW-1:0] MaxCount = 17'd65536;

	localparam logic [OpW-1:0] OP_INSERT = 2'd0;
	localparam logic [OpW-1:0] OP_COUNT  = 2'd1;
	localparam logic [OpW-1:0] OP_CLEAR  = 2'd2;

endpackage

[rtl/rpcfen_if.sv]
// Valid/ready channel interfaces for requests and count results.
// Depends on rpcfen_pkg for the payload widths.
interface rpcfen_in_if import rpcfen_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OpW-1:0]    opcode;
	logic [CoordW-1:0] x_low;
	logic [CoordW-1:0] y_low;
	logic [CoordW-1:0] x_high;
	logic [CoordW-1:0] y_high;

	modport source (output valid, opcode, x_low, y_low, x_high, y_high, input ready);
	modport sink   (input valid, opcode, x_low, y_low, x_high, y_high, output ready);
endinterface

interface rpcfen_out_if import rpcfen_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CountW-1:0] point_count;

	modport source (output valid, point_count, input ready);
	modport sink   (input valid, point_count, output ready);
endinterface

[rtl/rectangle_point_count_fenwick_2d_unit.sv]
// Insert: reads and writes up to N <= (log2(GRID_SIZE)+1)^2 tree nodes (<= 81 at 256).
// Count: one tree node per cycle through the single counter memory read
// port. Clear: sweeps all 2^(2*IW) memory entries, IW = clog2(GRID_SIZE+1).
// One request at a time; a finished count waits in the output register.
// Reset (arst_n low, asynchronous) starts the same memory-clearing sweep,
// during which no request is taken.
module rectangle_point_count_fenwick_2d_unit import rpcfen_pkg::*; #(
	parameter int GRID_SIZE = GridSizeDef
) (
	input  logic        clk,
	input  logic        arst_n,
	rpcfen_in_if.sink   cmd,
	rpcfen_out_if.source res
);

	localparam int IW = $clog2(GRID_SIZE + 1);
	localparam int AW = 2 * IW;
	localparam logic [IW:0] GridIdx = (IW+1)'(GRID_SIZE);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_VCHK   = 4'd2;
	localparam logic [3:0] S_VTEST  = 4'd3;
	localparam logic [3:0] S_ADD_RD = 4'd4;
	localparam logic [3:0] S_ADD_WR = 4'd5;
	localparam logic [3:0] S_QUERY  = 4'd6;
	localparam logic [3:0] S_FINISH = 4'd7;

	logic [3:0]        state_q;
	logic [AW-1:0]     clr_q;
	logic [IW-1:0]     i_q, j_q, base_j_q;
	logic [IW-1:0]     vx_q, vy_q;
	logic [IW-1:0]     qxl_q, qyl_q, qxh_q, qyh_q;
	logic [1:0]        term_q;
	logic              pend_q, pend_sub_q;
	logic [CountW-1:0] acc_q;
	logic              res_valid_q;
	logic [CountW-1:0] res_count_q;

	// memories
	logic [CountW-1:0] fen_mem [2**AW];
	logic              vis_mem [2**AW];
	logic [CountW-1:0] rdata_q;
	logic              vis_rd_q;

	logic              accept;
	logic [IW-1:0]     xh_sat, yh_sat;
	logic              ins_ok, rect_ok;
	logic [IW:0]       i_ext, j_ext, i_low, j_low, i_up, j_up;
	logic [IW-1:0]     i_dn, j_dn;
	logic              fen_we;
	logic [AW-1:0]     fen_waddr;
	logic [CountW-1:0] fen_wdata;
	logic              vis_we;
	logic [AW-1:0]     vis_waddr;
	logic              vis_wdata;
	logic              out_free;
	logic [1:0]        term_nx;

	assign accept   = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign out_free = !res_valid_q || res.ready;
	assign term_nx  = term_q + 2'd1;

	always_comb begin
		xh_sat = (32'(cmd.x_high) >= GRID_SIZE) ? IW'(GRID_SIZE - 1) : IW'(cmd.x_high);
		yh_sat = (32'(cmd.y_high) >= GRID_SIZE) ? IW'(GRID_SIZE - 1) : IW'(cmd.y_high);
		ins_ok = (32'(cmd.x_low) < GRID_SIZE) && (32'(cmd.y_low) < GRID_SIZE);
		rect_ok = (32'(cmd.x_low) <= 32'(xh_sat)) && (32'(cmd.y_low) <= 32'(yh_sat));
	end

	// Fenwick index stepping: lowest set bit, climb for add, descend for prefix
	always_comb begin
		i_ext = {1'b0, i_q};
		j_ext = {1'b0, j_q};
		i_low = i_ext & (~i_ext + (IW+1)'(1));
		j_low = j_ext & (~j_ext + (IW+1)'(1));
		i_up  = i_ext + i_low;
		j_up  = j_ext + j_low;
		i_dn  = i_q - i_low[IW-1:0];
		j_dn  = j_q - j_low[IW-1:0];
	end

	always_comb begin
		fen_we    = 1'b0;
		fen_waddr = {i_q, j_q};
		fen_wdata = rdata_q + CountW'(1);
		vis_we    = 1'b0;
		vis_waddr = {vx_q, vy_q};
		vis_wdata = 1'b1;
		case (state_q)
			S_CLEAR: begin
				fen_we    = 1'b1;
				fen_waddr = clr_q;
				fen_wdata = '0;
				vis_we    = 1'b1;
				vis_waddr = clr_q;
				vis_wdata = 1'b0;
			end
			S_VTEST: vis_we = !vis_rd_q;
			S_ADD_WR: fen_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= fen_mem[{i_q, j_q}];
		if (fen_we) begin
			fen_mem[fen_waddr] <= fen_wdata;
		end
	end

	always_ff @(posedge clk) begin
		vis_rd_q <= vis_mem[{vx_q, vy_q}];
		if (vis_we) begin
			vis_mem[vis_waddr] <= vis_wdata;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q  <= IW'(cmd.x_low);
			vy_q  <= IW'(cmd.y_low);
			qxl_q <= IW'(cmd.x_low);
			qyl_q <= IW'(cmd.y_low);
			qxh_q <= xh_sat + IW'(1);
			qyh_q <= yh_sat + IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			i_q        <= '0;
			j_q        <= '0;
			base_j_q   <= '0;
			term_q     <= '0;
			pend_q     <= 1'b0;
			pend_sub_q <= 1'b0;
			acc_q      <= '0;
		end else begin
			pend_q <= (state_q == S_QUERY) && (i_q != '0) && (j_q != '0);
			if (pend_q) begin
				acc_q <= pend_sub_q ? acc_q - rdata_q : acc_q + rdata_q;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (cmd.opcode)
							OP_INSERT: begin
								if (ins_ok) begin
									state_q <= S_VCHK;
								end
							end
							OP_COUNT: begin
								acc_q <= '0;
								if (rect_ok) begin
									term_q   <= '0;
									i_q      <= xh_sat + IW'(1);
									j_q      <= yh_sat + IW'(1);
									base_j_q <= yh_sat + IW'(1);
									state_q  <= S_QUERY;
								end else begin
									state_q <= S_FINISH;
								end
							end
							OP_CLEAR: begin
								clr_q   <= '0;
								state_q <= S_CLEAR;
							end
							default: ;
						endcase
					end
				end
				S_VCHK: state_q <= S_VTEST;
				S_VTEST: begin
					if (vis_rd_q) begin
						state_q <= S_IDLE;
					end else begin
						i_q      <= vx_q + IW'(1);
						j_q      <= vy_q + IW'(1);
						base_j_q <= vy_q + IW'(1);
						state_q  <= S_ADD_RD;
					end
				end
				S_ADD_RD: state_q <= S_ADD_WR;
				S_ADD_WR: begin
					if (j_up <= GridIdx) begin
						j_q     <= j_up[IW-1:0];
						state_q <= S_ADD_RD;
					end else if (i_up <= GridIdx) begin
						i_q     <= i_up[IW-1:0];
						j_q     <= base_j_q;
						state_q <= S_ADD_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_QUERY: begin
					if (i_q != '0 && j_q != '0) begin
						pend_sub_q <= term_q[0] ^ term_q[1];
						if (j_dn == '0) begin
							i_q <= i_dn;
							j_q <= base_j_q;
						end else begin
							j_q <= j_dn;
						end
					end else if (term_q == 2'd3) begin
						state_q <= S_FINISH;
					end else begin
						// next prefix: bit 1 picks the low x edge, bit 0 the low y edge
						term_q   <= term_nx;
						i_q      <= term_nx[1] ? qxl_q : qxh_q;
						j_q      <= term_nx[0] ? qyl_q : qyh_q;
						base_j_q <= term_nx[0] ? qyl_q : qyh_q;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FINISH && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			res_count_q <= acc_q;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.point_count = res_count_q;

endmodule

[rtl/rpcfen_checker.sv]
// Port-level checks for the rectangle point counter, bound to its top level.
// Depends on rpcfen_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpcfen_checker import rpcfen_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic [OpW-1:0]    cmd_opcode,
	input logic              res_valid,
	input logic              res_ready,
	input logic [CountW-1:0] res_point_count
);

	`RPC_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid, "count dropped while stalled")
	`RPC_ASSERT_NXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_point_count), "count changed while stalled")
	`RPC_ASSERT_NXT(a_count_busy, clk, arst_n, cmd_valid && cmd_ready && cmd_opcode == OP_COUNT, !cmd_ready, "new request taken during a count")
	`RPC_ASSERT_IMP(a_count_range, clk, arst_n, res_valid, res_point_count <= MaxCount, "count above grid capacity")

endmodule

bind rectangle_point_count_fenwick_2d_unit rpcfen_checker u_rpcfen_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.cmd_opcode      (cmd.opcode),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_point_count (res.point_count)
);
